>>> sv/acrfe_pkg.sv
package acrfe_pkg;

  localparam int unsigned HdrLen   = 8;
  localparam int unsigned StateLen = 19;
  localparam int unsigned NumCells = HdrLen + StateLen;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgHeader = 2'd0,
    CfgTplLow = 2'd1,
    CfgTplMid = 2'd2,
    CfgTplHigh = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] PowerOnBits  = 8'b1001_0000;
  localparam logic [7:0] PowerOffBits = 8'b0001_0000;

  // one byte slot of the frame line
  typedef struct packed {
    logic       valid;
    logic       state;
    logic       last;
    logic [7:0] data;
  } cell_t;

  // per-cycle control shared by all cells
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] mode_code(input logic [1:0] m);
    logic [7:0] r;
    unique case (m)
      2'd0: r = 8'h00;
      2'd1: r = 8'h02;
      2'd2: r = 8'h0C;
      2'd3: r = 8'h04;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // codes 6 and 7 fall back to auto
  function automatic logic [7:0] swing_code(input logic [2:0] s);
    logic [7:0] r;
    unique case (s)
      3'd1: r = 8'h80;
      3'd2: r = 8'h40;
      3'd3: r = 8'hC0;
      3'd4: r = 8'h20;
      3'd5: r = 8'hA0;
      default: r = 8'hF0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fan_code(input logic [2:0] f);
    logic [7:0] r;
    unique case (f)
      3'd1: r = 8'h0C;
      3'd2: r = 8'h02;
      3'd3: r = 8'h0A;
      3'd4: r = 8'h06;
      3'd5: r = 8'h0E;
      default: r = 8'h05;
    endcase
    return r;
  endfunction

endpackage

>>> sv/acrfe_cell.sv
module acrfe_cell import acrfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     load_i,
  input  cell_t     shift_i,
  output cell_t     cell_o
);

  cell_t cell_q, cell_d;

  always_comb begin
    priority if (ctl_i.load) begin
      cell_d = load_i;
    end else if (ctl_i.shift) begin
      cell_d = shift_i;
    end else begin
      cell_d = cell_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> sv/acrfe_csum.sv
module acrfe_csum import acrfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     next_i,
  output cell_t     head_o
);

  logic [7:0] acc_q, acc_d;

  // sum of bit-reversed state bytes as they enter the head cell
  always_comb begin
    priority if (ctl_i.load) begin
      acc_d = '0;
    end else if (ctl_i.shift && next_i.valid && next_i.state && !next_i.last) begin
      acc_d = acc_q + flip8(next_i.data);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    head_o = next_i;
    if (next_i.last) begin
      head_o.data = flip8(acc_q);
    end
  end

endmodule

>>> sv/ac_remote_frame_encoder_core.sv
// Remote-control frame encoder: each accepted climate-setting item (power, mode,
// temperature, swing, fan) becomes a 27-byte frame, 8 header bytes taken from the
// header register and then 19 state bytes built from the template registers with
// the setting fields patched in and a checksum byte at the end (last_byte_o high).
// The frame is loaded in parallel into a line of 27 byte cells that shifts toward
// the output; the head cell is the output register. One byte leaves per cycle
// unless the output stalls; a new item is taken only when no byte of the previous
// frame waits behind the head, with no stall in the same cycle that its checksum
// byte is taken. The checksum is accumulated byte by byte as state bytes enter
// the head cell. Write configuration only while idle; the block does not check.
module ac_remote_frame_encoder_core import acrfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        power_on_i,
  input  logic [1:0]  climate_mode_i,
  input  logic [4:0]  temperature_i,
  input  logic [2:0]  swing_setting_i,
  input  logic [2:0]  fan_setting_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        in_state_section_o,
  output logic        last_byte_o
);

  // configuration registers
  logic [63:0] header_q, tpl_low_q, tpl_mid_q;
  logic [15:0] tpl_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= '0;
      tpl_low_q  <= '0;
      tpl_mid_q  <= '0;
      tpl_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHeader:  header_q   <= cfg_data_i;
        CfgTplLow:  tpl_low_q  <= cfg_data_i;
        CfgTplMid:  tpl_mid_q  <= cfg_data_i;
        CfgTplHigh: tpl_high_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // frame line
  cell_t     cell_q  [NumCells];
  cell_t     load_v  [NumCells];
  cell_t     shift_v [NumCells];
  cell_t     head_in;
  cell_ctl_t ctl;
  logic      tail_busy;
  logic      advance;

  // head slot free or its byte taken this cycle
  assign advance = !cell_q[0].valid || !out_stall_i;

  // anything still waiting behind the head
  always_comb begin
    tail_busy = 1'b0;
    for (int i = 1; i < NumCells; i++) begin
      tail_busy = tail_busy | cell_q[i].valid;
    end
  end

  // a new frame fits once the whole line drains this cycle
  assign in_stall_o = !(advance && !tail_busy);
  assign ctl.load   = in_valid_i && !in_stall_o;
  assign ctl.shift  = advance;

  // frame assembly for the parallel load
  logic [7:0] st [StateLen];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      st[k]     = tpl_low_q[8*k +: 8];
      st[8 + k] = tpl_mid_q[8*k +: 8];
    end
    st[16] = tpl_high_q[7:0];
    st[17] = tpl_high_q[15:8];
    // power and mode
    st[5] = (power_on_i ? PowerOnBits : PowerOffBits) | mode_code(climate_mode_i);
    // reversed temperature, shifted down one
    st[6] = flip8({3'b000, temperature_i}) >> 1;
    // swing and fan
    st[8] = swing_code(swing_setting_i) | fan_code(fan_setting_i);
    // checksum slot, filled in on the way into the head cell
    st[18] = '0;

    for (int k = 0; k < HdrLen; k++) begin
      load_v[k].valid = 1'b1;
      load_v[k].state = 1'b0;
      load_v[k].last  = 1'b0;
      load_v[k].data  = header_q[8*k +: 8];
    end
    for (int k = 0; k < StateLen; k++) begin
      load_v[HdrLen + k].valid = 1'b1;
      load_v[HdrLen + k].state = 1'b1;
      load_v[HdrLen + k].last  = (k == StateLen - 1);
      load_v[HdrLen + k].data  = st[k];
    end
  end

  // neighbor hand-off, head fed through the checksum stage
  always_comb begin
    shift_v[0] = head_in;
    for (int i = 1; i < NumCells - 1; i++) begin
      shift_v[i] = cell_q[i + 1];
    end
    shift_v[NumCells - 1] = '0;
  end

  acrfe_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .next_i (cell_q[1]),
    .head_o (head_in)
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    acrfe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .load_i  (load_v[g]),
      .shift_i (shift_v[g]),
      .cell_o  (cell_q[g])
    );
  end

  // head cell drives the result channel
  assign out_valid_o        = cell_q[0].valid;
  assign frame_byte_o       = cell_q[0].data;
  assign in_state_section_o = cell_q[0].state;
  assign last_byte_o        = cell_q[0].last;

  // checksum byte always belongs to the state section
  a_last_in_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> in_state_section_o)
    else $error("last byte outside state section");

  // an accepted item shows its first byte next cycle
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o && !in_state_section_o)
    else $error("frame not presented after accept");

  // a frame leaves without gaps until its checksum byte
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o |=> out_valid_o)
    else $error("gap inside frame");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import acrfe_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  // swing and fan codes above MaxPosition fall back to auto
  localparam logic [2:0] MaxPosition  = 3'd5;
  localparam logic [2:0] AutoPosition = 3'd0;
  localparam logic [5:0][7:0] SwingPattern = {8'hA0, 8'h20, 8'hC0, 8'h40, 8'h80, 8'hF0};
  localparam logic [5:0][7:0] FanPattern   = {8'h0E, 8'h06, 8'h0A, 8'h02, 8'h0C, 8'h05};

  typedef enum logic [1:0] {ModeAuto, ModeHeat, ModeCool, ModeDry} climate_mode_e;

  typedef struct packed {
    logic          power;
    climate_mode_e mode;
    logic [4:0]    temp;
    logic [2:0]    swing;
    logic [2:0]    fan;
  } setting_t;

  typedef struct packed {
    logic [7:0] data;
    logic       state;
    logic       last;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgHeader;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        power_on_i = 1'b0;
  logic [1:0]  climate_mode_i = ModeAuto;
  logic [4:0]  temperature_i = '0;
  logic [2:0]  swing_setting_i = '0;
  logic [2:0]  fan_setting_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        in_state_section_o;
  logic        last_byte_o;

  // our copy of the configuration registers, all cleared by reset
  logic [63:0] header_reg   = '0;
  logic [63:0] tpl_low_reg  = '0;
  logic [63:0] tpl_mid_reg  = '0;
  logic [15:0] tpl_high_reg = '0;

  frame_byte_t pending_bytes[$];
  int          mismatches   = 0;
  int          cycle_count  = 0;
  int          stall_pct    = 20;
  bit          sender_gaps  = 1'b1;
  int          hold_off_len = 0;

  ac_remote_frame_encoder_core uut (.*);

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(99) < 10) return $urandom_range(20, 8);
    return $urandom_range(3);
  endfunction

  function automatic logic [7:0] mirror_bits(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r = {r[6:0], v[i]};
    return r;
  endfunction

  // builds the 27 bytes of the frame for one setting and queues them
  function automatic void queue_frame(input setting_t s);
    logic [7:0] st [StateLen];
    logic [7:0] mode_bits;
    logic [7:0] sum;
    logic [2:0] swing;
    logic [2:0] fan;
    frame_byte_t fb;
    for (int k = 0; k < 8; k++) begin
      st[k]     = tpl_low_reg[8*k +: 8];
      st[8 + k] = tpl_mid_reg[8*k +: 8];
    end
    st[16] = tpl_high_reg[7:0];
    st[17] = tpl_high_reg[15:8];
    case (s.mode)
      ModeAuto: mode_bits = 8'h00;
      ModeHeat: mode_bits = 8'h02;
      ModeCool: mode_bits = 8'h0C;
      default:  mode_bits = 8'h04;
    endcase
    st[5] = (s.power ? PowerOnBits : PowerOffBits) | mode_bits;
    st[6] = mirror_bits({3'b000, s.temp}) >> 1;
    swing = (s.swing > MaxPosition) ? AutoPosition : s.swing;
    fan   = (s.fan > MaxPosition) ? AutoPosition : s.fan;
    st[8] = SwingPattern[swing] | FanPattern[fan];
    sum = '0;
    for (int k = 0; k < StateLen - 1; k++) sum += mirror_bits(st[k]);
    st[StateLen - 1] = mirror_bits(sum);
    for (int k = 0; k < HdrLen; k++) begin
      fb = '{data: header_reg[8*k +: 8], state: 1'b0, last: 1'b0};
      pending_bytes.push_back(fb);
    end
    for (int k = 0; k < StateLen; k++) begin
      fb = '{data: st[k], state: 1'b1, last: (k == StateLen - 1)};
      pending_bytes.push_back(fb);
    end
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    s.power = 1'($urandom_range(1));
    s.mode  = climate_mode_e'(2'($urandom_range(3)));
    s.temp  = 5'($urandom_range(31));
    s.swing = 3'($urandom_range(7));
    s.fan   = 3'($urandom_range(7));
    return s;
  endfunction

  // valid stays high on return so a following item can go out back to back;
  // whoever stops sending lowers it
  task automatic offer_setting(input setting_t s);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    power_on_i      <= s.power;
    climate_mode_i  <= s.mode;
    temperature_i   <= s.temp;
    swing_setting_i <= s.swing;
    fan_setting_i   <= s.fan;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_frame(s);
  endtask

  // stop sending and let every queued frame byte come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high so writes can follow back to back
  task automatic write_one(input cfg_idx_e idx, input logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgHeader: header_reg  = value;
      CfgTplLow: tpl_low_reg = value;
      CfgTplMid: tpl_mid_reg = value;
      default:   tpl_high_reg = value[15:0];
    endcase
  endtask

  task automatic load_registers(input logic [63:0] hdr, low, mid, high);
    write_one(CfgHeader, hdr);
    write_one(CfgTplLow, low);
    write_one(CfgTplMid, mid);
    write_one(CfgTplHigh, high);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // receiver: runs of stall or no stall; a requested hold-off wins
  initial begin : receiver_stalls
    int  run_left;
    bit  level;
    run_left = 0;
    level    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        level        = 1'b1;
        run_left     = hold_off_len;
        hold_off_len = 0;
      end else if (run_left == 0) begin
        level    = ($urandom_range(99) < stall_pct);
        run_left = pick_gap() + 1;
      end
      out_stall_i <= level;
      run_left--;
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // every byte taken from the block is compared with the oldest queued one
  always @(posedge clk_i) begin : byte_check
    frame_byte_t want;
    if (rst_ni && out_valid_o !== 1'b0 && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: frame byte with none expected, expected none, actual %h",
                 $time, frame_byte_o);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("frame_byte", want.data, frame_byte_o);
        check_field("in_state_section", {7'b0, want.state}, {7'b0, in_state_section_o});
        check_field("last_byte", {7'b0, want.last}, {7'b0, last_byte_o});
      end
    end
  end

  // registers still at their reset value
  task automatic test_reset_values();
    offer_setting(random_setting());
    offer_setting(random_setting());
    wait_idle();
  endtask

  // every mode, every swing and fan code including the auto fallbacks,
  // temperature and power extremes
  task automatic test_setting_extremes();
    setting_t s;
    load_registers(random_word(), random_word(), random_word(), random_word());
    for (int k = 0; k < 8; k++) begin
      s.power = k[0];
      s.mode  = climate_mode_e'(k[1:0]);
      s.temp  = (k == 0) ? 5'd0 : (k == 7) ? 5'd31 : 5'($urandom_range(31));
      s.swing = k[2:0];
      s.fan   = 3'd7 - k[2:0];
      offer_setting(s);
    end
    offer_setting('0);
    offer_setting('1);
    s = random_setting();
    s.temp = 5'b10000;
    offer_setting(s);
    s.temp = 5'b00001;
    offer_setting(s);
    wait_idle();
  endtask

  // all-zero and all-one templates, stray high bits on the 16-bit register
  task automatic test_register_extremes();
    load_registers('0, '0, '0, '0);
    repeat (3) offer_setting(random_setting());
    wait_idle();
    load_registers('1, '1, '1, '1);
    repeat (3) offer_setting(random_setting());
    wait_idle();
    load_registers(64'h55AA_55AA_55AA_55AA, 64'hAA55_AA55_AA55_AA55,
                   64'h0F0F_F0F0_0F0F_F0F0, 64'hDEAD_BEEF_1234_A55A);
    repeat (2) offer_setting(random_setting());
    wait_idle();
  endtask

  // several register settings under varied sender gaps and receiver stall rates
  task automatic test_random_settings();
    for (int phase = 0; phase < 5; phase++) begin
      load_registers(random_word(), random_word(), random_word(), random_word());
      stall_pct   = (phase * 15) % 60;
      sender_gaps = phase[0];
      repeat (50) offer_setting(random_setting());
      wait_idle();
    end
  endtask

  // receiver holds off while items keep coming, so the input backs up
  task automatic test_output_hold_off();
    load_registers(random_word(), random_word(), random_word(), random_word());
    sender_gaps  = 1'b0;
    stall_pct    = 0;
    hold_off_len = 300;
    repeat (36) offer_setting(random_setting());
    wait_idle();
    sender_gaps = 1'b1;
    stall_pct   = 20;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_setting_extremes();
    test_register_extremes();
    test_random_settings();
    test_output_hold_off();
    repeat (NumCells) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> ac_remote_frame_encoder_core.f
sv/acrfe_pkg.sv
sv/acrfe_cell.sv
sv/acrfe_csum.sv
sv/ac_remote_frame_encoder_core.sv
tb/tb_top.sv
